// ===== src/indexed_list_store_assert.svh =====
// assertion macros used by the indexed list store
`ifndef INDEXED_LIST_STORE_ASSERT_SVH
`define INDEXED_LIST_STORE_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define ILS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define ILS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ils_pkg.sv =====
// types and constants of the indexed list store
`timescale 1ns / 1ps

package ils_pkg;

    // default number of entries
    localparam int ILS_CAPACITY = 64;

    // field widths
    localparam int ACTION_W  = 3;
    localparam int POS_W     = 7;
    localparam int VALUE_W   = 32;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 7;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;

    // read value returned for every item that is not a good read
    localparam logic [VALUE_W-1:0] NO_VALUE = '1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_READ        = 3'd0,
        ACT_INSERT_AT   = 3'd1,
        ACT_INSERT_HEAD = 3'd2,
        ACT_INSERT_TAIL = 3'd3,
        ACT_DELETE      = 3'd4
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE  = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SHIFT,
        S_SHIFT_WR,
        S_READ_WAIT,
        S_DONE
    } state_t;

endpackage

// ===== src/ils_ram.sv =====
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module ils_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/indexed_list_store.sv =====
// Ordered list of signed 32-bit values in a CAPACITY-entry ram. One item is taken
// at a time: s_tready is high only while the sequencer is idle, and a finished result
// waits in the output register while the next item is already accepted. A good read
// passes S_DECODE, S_READ_WAIT and S_DONE on its way to the result register; a failed
// or unused action passes S_DECODE and S_DONE. An insert at position p moves the
// entries from p up to the last one place up, and a delete at p moves those above p
// one place down, each through the single ram read port (read in S_SHIFT, written one
// place over in S_SHIFT_WR) under one shared index adder and comparator. The ram needs
// no clearing pass: only entries below the count are ever read.
`timescale 1ns / 1ps

`include "indexed_list_store_assert.svh"

module indexed_list_store #(
    parameter int CAPACITY = ils_pkg::ILS_CAPACITY
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // action [2:0], position [9:3], item_value [41:10], zero above
    input  logic [ils_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // read_value [31:0], status [33:32], entry_count [40:34], zero above
    output logic [ils_pkg::M_TDATA_W-1:0] m_tdata
);

    import ils_pkg::*;

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int AW   = $clog2(CAPACITY);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;
    localparam int PADW = M_TDATA_W - VALUE_W - STATUS_W - COUNT_W;

    // control state
    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            out_valid_reg, out_valid_next;

    // item and working registers
    action_t         act_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [VALUE_W-1:0] val_reg;
    logic [CW-1:0]   idx_reg, idx_next;
    logic [CW-1:0]   tgt_reg, tgt_next;
    logic            ins_reg, ins_next;
    logic [VALUE_W-1:0] rv_reg, rv_next;
    status_t         st_reg, st_next;

    // output register
    logic [VALUE_W-1:0] out_rv_reg;
    status_t            out_st_reg;
    logic [COUNT_W-1:0] out_count_reg;

    // ram port signals
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [VALUE_W-1:0] ram_wdata;
    logic [AW-1:0]   ram_raddr;
    logic [VALUE_W-1:0] ram_rdata;

    // shared index unit
    logic [CW-1:0]   step_sum;
    logic [CW-1:0]   cmp_a, cmp_b;
    logic            cmp_lt;

    logic [CMPW-1:0] pos_x, cnt_x;
    logic            s_fire, out_load;

    ils_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(CAPACITY)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PADW{1'b0}}, out_count_reg, out_st_reg, out_rv_reg};

    assign pos_x = CMPW'(pos_reg);
    assign cnt_x = CMPW'(count_reg);

    // one adder steps the index, one comparator ends the shift
    assign step_sum = ins_reg ? (idx_reg - CW'(1)) : (idx_reg + CW'(1));
    assign cmp_a    = ins_reg ? tgt_reg : step_sum;
    assign cmp_b    = ins_reg ? idx_reg : count_reg;
    assign cmp_lt   = (cmp_a < cmp_b);

    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || m_tready);

    // sequencer: next state and ram control
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        tgt_next       = tgt_reg;
        ins_next       = ins_reg;
        rv_next        = rv_reg;
        st_next        = st_reg;
        out_valid_next = out_valid_reg;
        ram_we         = 1'b0;
        ram_waddr      = idx_reg[AW-1:0];
        ram_wdata      = ram_rdata;
        ram_raddr      = step_sum[AW-1:0];

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_fire)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                rv_next    = NO_VALUE;
                st_next    = STAT_DONE;
                state_next = S_DONE;
                case (act_reg)
                    ACT_READ:
                    begin
                        if (pos_x < cnt_x)
                        begin
                            ram_raddr  = AW'(pos_x);
                            state_next = S_READ_WAIT;
                        end
                        else
                        begin
                            st_next = STAT_RANGE;
                        end
                    end
                    ACT_INSERT_AT, ACT_INSERT_HEAD, ACT_INSERT_TAIL:
                    begin
                        if (act_reg == ACT_INSERT_AT && pos_x > cnt_x)
                        begin
                            st_next = STAT_RANGE;
                        end
                        else if (count_reg >= CW'(CAPACITY))
                        begin
                            st_next = STAT_FULL;
                        end
                        else
                        begin
                            ins_next   = 1'b1;
                            idx_next   = count_reg;
                            state_next = S_SHIFT;
                            if (act_reg == ACT_INSERT_HEAD)
                            begin
                                tgt_next = '0;
                            end
                            else if (act_reg == ACT_INSERT_TAIL)
                            begin
                                tgt_next = count_reg;
                            end
                            else
                            begin
                                tgt_next = CW'(pos_x);
                            end
                        end
                    end
                    ACT_DELETE:
                    begin
                        if (pos_x >= cnt_x)
                        begin
                            st_next = STAT_RANGE;
                        end
                        else
                        begin
                            ins_next   = 1'b0;
                            idx_next   = CW'(pos_x);
                            state_next = S_SHIFT;
                        end
                    end
                    default:
                    begin
                        st_next = STAT_DONE;
                    end
                endcase
            end
            S_SHIFT:
            begin
                if (cmp_lt)
                begin
                    // fetch the neighbor that moves into idx
                    ram_raddr  = step_sum[AW-1:0];
                    state_next = S_SHIFT_WR;
                end
                else if (ins_reg)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = tgt_reg[AW-1:0];
                    ram_wdata  = val_reg;
                    count_next = count_reg + CW'(1);
                    state_next = S_DONE;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_DONE;
                end
            end
            S_SHIFT_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = idx_reg[AW-1:0];
                ram_wdata  = ram_rdata;
                idx_next   = step_sum;
                state_next = S_SHIFT;
            end
            S_READ_WAIT:
            begin
                rv_next    = ram_rdata;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working registers of the current item
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        tgt_reg <= tgt_next;
        ins_reg <= ins_next;
        rv_reg  <= rv_next;
        st_reg  <= st_next;
        if (s_fire)
        begin
            act_reg <= action_t'(s_tdata[ACTION_W-1:0]);
            pos_reg <= s_tdata[ACTION_W +: POS_W];
            val_reg <= s_tdata[ACTION_W+POS_W +: VALUE_W];
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_rv_reg    <= rv_reg;
            out_st_reg    <= st_reg;
            out_count_reg <= COUNT_W'(count_reg);
        end
    end

    // checks on the sequencer and result
    `ILS_ASSERT_IMPLY(a_count_bound, clk, rst_n, 1'b1,
        count_reg <= CW'(CAPACITY), "count above capacity")
    `ILS_ASSERT_NEXT(a_count_only_at_end, clk, rst_n, state_reg != S_SHIFT,
        count_reg == $past(count_reg), "count changed outside shift end")
    `ILS_ASSERT_IMPLY(a_full_count, clk, rst_n, out_valid_reg && out_st_reg == STAT_FULL,
        out_count_reg == COUNT_W'(CAPACITY), "full status with store not full")
    `ILS_ASSERT_IMPLY(a_bad_no_value, clk, rst_n, out_valid_reg && out_st_reg != STAT_DONE,
        out_rv_reg == NO_VALUE, "failed item carries a value")

endmodule
